### rtl/core/bmbv_pkg.sv
package bmbv_pkg;

  localparam int FIXED_BUFFER_BYTES_DEF = 12;

  localparam int BYTE_TOTAL_W = 24;
  localparam int FEATURE_W    = 17;
  localparam int POINT_W      = 20;
  localparam int GRID_W       = 20;
  localparam int COUNT_W      = 16;
  localparam int BYTES_LEFT_W = 18;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BLOCK_BYTES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FEATURES    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_POINTS      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_GRID_CELLS  = 2'd3;

  localparam logic [BYTE_TOTAL_W-1:0] MAX_BLOCK_BYTES_RST = 24'd65536;
  localparam logic [FEATURE_W-1:0]    MAX_FEATURES_RST    = 17'd4096;
  localparam logic [POINT_W-1:0]      MAX_POINTS_RST      = 20'd65535;
  localparam logic [GRID_W-1:0]       MAX_GRID_CELLS_RST  = 20'd4096;

  localparam logic [7:0] MAGIC_0 = 8'h46;
  localparam logic [7:0] MAGIC_1 = 8'h4D;
  localparam logic [7:0] MAGIC_2 = 8'h42;

  localparam logic [1:0] VERSION_1 = 2'd1;
  localparam logic [1:0] VERSION_2 = 2'd2;

  localparam logic [3:0] FIX_LEN_POLYGON  = 4'd11;
  localparam logic [3:0] FIX_LEN_POLYLINE = 4'd12;
  localparam logic [3:0] CELL_MAX         = 4'd15;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_PG_COUNT = 4'd1,
    PH_PG_FIXED = 4'd2,
    PH_PG_NPTS  = 4'd3,
    PH_PG_PTS   = 4'd4,
    PH_PL_COUNT = 4'd5,
    PH_PL_FIXED = 4'd6,
    PH_PL_NPTS  = 4'd7,
    PH_PL_PTS   = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPT      = 2'd0,
    ST_REJECT      = 2'd1,
    ST_END_VALID   = 2'd2,
    ST_END_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_TOTAL_W-1:0] max_block_bytes;
    logic [FEATURE_W-1:0]    max_features;
    logic [POINT_W-1:0]      max_points;
    logic [GRID_W-1:0]       max_grid_cells;
  } limits_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] version;
  } result_t;

  // cell index from the high byte of a signed 16-bit coordinate
  function automatic logic [3:0] cell_of_hi(input logic [7:0] hi);
    logic [3:0] c;
    if (hi[7]) begin
      c = 4'd0;
    end else if (hi[6:4] != 3'd0) begin
      c = CELL_MAX;
    end else begin
      c = hi[3:0];
    end
    return c;
  endfunction

  function automatic logic [3:0] fixed_len(input logic poly, input logic [1:0] version);
    logic [3:0] len;
    len = poly ? FIX_LEN_POLYLINE : FIX_LEN_POLYGON;
    if (version == VERSION_2) begin
      len = len + 4'd1;
    end
    return len;
  endfunction

endpackage

### rtl/core/binary_map_block_validator.sv
// Checks a binary map block streamed one byte per transaction: magic "FMB",
// version 1 or 2, polygon and polyline sections with their records, and the
// byte, feature, point and grid-cell limits set over the cfg_ port. Every
// input transaction yields exactly one result transaction. One transaction
// is taken per clock unless the output stalls; each byte passes the input
// register, combinational parse step and result register. Any failure is
// sticky until reset; an end transaction (in_tuser high) returns the verdict
// and leaves the state untouched. Write the limits only while no transaction
// is in flight.
module binary_map_block_validator #(
  parameter int FIXED_BUFFER_BYTES = bmbv_pkg::FIXED_BUFFER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // [0] end_of_block
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [1:0] status, [3:2] format_version
  input  logic                                cfg_we,
  input  logic [bmbv_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bmbv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bmbv_pkg::*;

  limits_t    lim_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eob_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res;
  logic       adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.max_block_bytes <= MAX_BLOCK_BYTES_RST;
      lim_r.max_features    <= MAX_FEATURES_RST;
      lim_r.max_points      <= MAX_POINTS_RST;
      lim_r.max_grid_cells  <= MAX_GRID_CELLS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_BLOCK_BYTES: lim_r.max_block_bytes <= cfg_wdata[BYTE_TOTAL_W-1:0];
        CFG_MAX_FEATURES:    lim_r.max_features    <= cfg_wdata[FEATURE_W-1:0];
        CFG_MAX_POINTS:      lim_r.max_points      <= cfg_wdata[POINT_W-1:0];
        CFG_MAX_GRID_CELLS:  lim_r.max_grid_cells  <= cfg_wdata[GRID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eob_r  <= in_tuser;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  bmbv_core #(
    .FIXED_BUFFER_BYTES(FIXED_BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (adv),
    .item_byte(s1_byte_r),
    .item_eob (s1_eob_r),
    .lim      (lim_r),
    .res      (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.version, out_res_r.status};

endmodule

### rtl/core/bmbv_core.sv
module bmbv_core #(
  parameter int FIXED_BUFFER_BYTES = bmbv_pkg::FIXED_BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        item_byte,
  input  logic              item_eob,
  input  bmbv_pkg::limits_t lim,
  output bmbv_pkg::result_t res
);
  import bmbv_pkg::*;

  localparam int FILL_W = $clog2(FIXED_BUFFER_BYTES + 1);
  localparam int IDX_W  = $clog2(FIXED_BUFFER_BYTES);

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              small_r [4];
  logic [2:0]              small_fill_r, small_fill_nxt;
  logic [1:0]              version_r, version_nxt;
  logic [COUNT_W-1:0]      records_left_r, records_left_nxt;
  logic [FEATURE_W-1:0]    feature_total_r, feature_total_nxt;
  logic [POINT_W-1:0]      point_total_r, point_total_nxt;
  logic [GRID_W-1:0]       grid_total_r, grid_total_nxt;
  logic [BYTE_TOTAL_W-1:0] byte_total_r, byte_total_nxt;
  logic [BYTES_LEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]              fixed_r [FIXED_BUFFER_BYTES];
  logic [FILL_W-1:0]       fixed_fill_r, fixed_fill_nxt;
  logic                    failed_r, failed_nxt;

  logic                    small_we;
  logic                    fixed_we;
  status_t                 status;

  logic [7:0]              view [FIXED_BUFFER_BYTES];
  logic [3:0]              x0, y0, x1, y1;
  logic                    bbox_empty;
  logic [9:0]              cells;
  logic [GRID_W:0]         grid_sum;

  always_comb begin
    for (int i = 0; i < FIXED_BUFFER_BYTES; i++) begin
      view[i] = (fixed_fill_r == FILL_W'(i)) ? item_byte : fixed_r[i];
    end
  end

  always_comb begin
    logic v2;
    v2 = (version_r == VERSION_2);
    x0 = cell_of_hi(v2 ? view[5]  : view[4]);
    y0 = cell_of_hi(v2 ? view[7]  : view[6]);
    x1 = cell_of_hi(v2 ? view[9]  : view[8]);
    y1 = cell_of_hi(v2 ? view[11] : view[10]);
    bbox_empty = (x0 > x1) || (y0 > y1);
    cells = (10'(x1) - 10'(x0) + 10'd1) * (10'(y1) - 10'(y0) + 10'd1);
    grid_sum = {1'b0, grid_total_r} + (GRID_W + 1)'(cells);
  end

  always_comb begin
    logic                    ok;
    logic [COUNT_W-1:0]      value;
    logic [BYTES_LEFT_W-1:0] left;
    logic [COUNT_W-1:0]      rec;
    phase_nxt         = phase_r;
    small_fill_nxt    = small_fill_r;
    version_nxt       = version_r;
    records_left_nxt  = records_left_r;
    feature_total_nxt = feature_total_r;
    point_total_nxt   = point_total_r;
    grid_total_nxt    = grid_total_r;
    byte_total_nxt    = byte_total_r;
    bytes_left_nxt    = bytes_left_r;
    fixed_fill_nxt    = fixed_fill_r;
    failed_nxt        = failed_r;
    small_we          = 1'b0;
    fixed_we          = 1'b0;
    ok                = 1'b1;
    value             = {item_byte, small_r[0]};
    left              = bytes_left_r - BYTES_LEFT_W'(1);
    rec               = records_left_r - COUNT_W'(1);
    status            = ST_ACCEPT;

    if (item_eob) begin
      status = (!failed_r && phase_r == PH_DONE) ? ST_END_VALID : ST_END_INVALID;
    end else if (failed_r) begin
      status = ST_REJECT;
    end else if (byte_total_r >= lim.max_block_bytes) begin
      ok = 1'b0;
    end else begin
      byte_total_nxt = byte_total_r + BYTE_TOTAL_W'(1);
      case (phase_r)
        PH_HEADER: begin
          if (small_fill_r < 3'd3) begin
            small_we       = 1'b1;
            small_fill_nxt = small_fill_r + 3'd1;
          end else begin
            small_fill_nxt = 3'd0;
            if (small_r[0] != MAGIC_0 || small_r[1] != MAGIC_1 || small_r[2] != MAGIC_2 ||
                (item_byte != 8'(VERSION_1) && item_byte != 8'(VERSION_2))) begin
              ok = 1'b0;
            end else begin
              version_nxt = item_byte[1:0];
              phase_nxt   = PH_PG_COUNT;
            end
          end
        end
        PH_PG_COUNT, PH_PL_COUNT, PH_PG_NPTS, PH_PL_NPTS: begin
          if (small_fill_r == 3'd0) begin
            small_we       = 1'b1;
            small_fill_nxt = 3'd1;
          end else begin
            small_fill_nxt = 3'd0;
            if (phase_r == PH_PG_COUNT) begin
              records_left_nxt = value;
              if (FEATURE_W'(value) > lim.max_features) begin
                ok = 1'b0;
              end else begin
                feature_total_nxt = FEATURE_W'(value);
                if (value == '0) begin
                  phase_nxt = PH_PL_COUNT;
                end else begin
                  phase_nxt      = PH_PG_FIXED;
                  bytes_left_nxt = BYTES_LEFT_W'(fixed_len(1'b0, version_r));
                  fixed_fill_nxt = '0;
                end
              end
            end else if (phase_r == PH_PL_COUNT) begin
              records_left_nxt = value;
              if ({1'b0, feature_total_r} + (FEATURE_W + 1)'(value) >
                  {1'b0, lim.max_features}) begin
                ok = 1'b0;
              end else begin
                feature_total_nxt = feature_total_r + FEATURE_W'(value);
                if (value == '0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt      = PH_PL_FIXED;
                  bytes_left_nxt = BYTES_LEFT_W'(fixed_len(1'b1, version_r));
                  fixed_fill_nxt = '0;
                end
              end
            end else begin
              if (value == '0) begin
                ok = 1'b0;
              end else if ({1'b0, point_total_r} + (POINT_W + 1)'(value) >
                           {1'b0, lim.max_points}) begin
                ok = 1'b0;
              end else begin
                point_total_nxt = point_total_r + POINT_W'(value);
                phase_nxt       = (phase_r == PH_PG_NPTS) ? PH_PG_PTS : PH_PL_PTS;
                bytes_left_nxt  = {value, 2'b00};
                fixed_fill_nxt  = '0;
              end
            end
          end
        end
        PH_PG_FIXED, PH_PL_FIXED, PH_PG_PTS, PH_PL_PTS: begin
          if (bytes_left_r == '0) begin
            ok = 1'b0;
          end else if (phase_r == PH_PG_FIXED &&
                       fixed_fill_r >= FILL_W'(FIXED_BUFFER_BYTES)) begin
            ok = 1'b0;
          end else begin
            if (phase_r == PH_PG_FIXED) begin
              fixed_we       = 1'b1;
              fixed_fill_nxt = fixed_fill_r + FILL_W'(1);
            end
            bytes_left_nxt = left;
            if (left == '0) begin
              if (phase_r == PH_PG_FIXED) begin
                if (!bbox_empty && grid_sum > {1'b0, lim.max_grid_cells}) begin
                  ok = 1'b0;
                end else begin
                  if (!bbox_empty) begin
                    grid_total_nxt = grid_sum[GRID_W-1:0];
                  end
                  phase_nxt = PH_PG_NPTS;
                end
              end else if (phase_r == PH_PL_FIXED) begin
                phase_nxt = PH_PL_NPTS;
              end else begin
                records_left_nxt = rec;
                if (rec == '0) begin
                  phase_nxt = (phase_r == PH_PL_PTS) ? PH_DONE : PH_PL_COUNT;
                end else begin
                  phase_nxt      = (phase_r == PH_PL_PTS) ? PH_PL_FIXED : PH_PG_FIXED;
                  bytes_left_nxt = BYTES_LEFT_W'(fixed_len(phase_r == PH_PL_PTS, version_r));
                  fixed_fill_nxt = '0;
                end
              end
            end
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end

    if (!ok) begin
      failed_nxt = 1'b1;
      status     = ST_REJECT;
    end
  end

  assign res.status  = status;
  assign res.version = version_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      small_fill_r    <= '0;
      version_r       <= '0;
      records_left_r  <= '0;
      feature_total_r <= '0;
      point_total_r   <= '0;
      grid_total_r    <= '0;
      byte_total_r    <= '0;
      bytes_left_r    <= '0;
      fixed_fill_r    <= '0;
      failed_r        <= 1'b0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      small_fill_r    <= small_fill_nxt;
      version_r       <= version_nxt;
      records_left_r  <= records_left_nxt;
      feature_total_r <= feature_total_nxt;
      point_total_r   <= point_total_nxt;
      grid_total_r    <= grid_total_nxt;
      byte_total_r    <= byte_total_nxt;
      bytes_left_r    <= bytes_left_nxt;
      fixed_fill_r    <= fixed_fill_nxt;
      failed_r        <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && small_we) begin
      small_r[small_fill_r[1:0]] <= item_byte;
    end
    if (step_en && fixed_we) begin
      fixed_r[fixed_fill_r[IDX_W-1:0]] <= item_byte;
    end
  end

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag cleared without reset");

  a_version_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    version_r != 2'd0 |=> $stable(version_r))
    else $error("version changed after header");

  a_done_stays: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left done phase");

  a_byte_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !failed_r && byte_total_r >= lim.max_block_bytes && !item_eob)
    |=> failed_r && $stable(byte_total_r))
    else $error("byte limit not enforced");

endmodule

### tb/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmbv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } feed_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;   // [7:0] data_byte
  logic                  in_tuser = 1'b0;   // [0] end_of_block
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [1:0] status, [3:2] format_version
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  binary_map_block_validator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  feed_t   bytes_to_send[$];
  result_t verdicts_due[$];

  bit          quiet = 1'b0;
  bit          scatter_ends = 1'b0;
  logic [1:0]  ver_sel = VERSION_1;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  // validator copy: limits
  logic [BYTE_TOTAL_W-1:0] lim_bytes = MAX_BLOCK_BYTES_RST;
  logic [FEATURE_W-1:0]    lim_feat  = MAX_FEATURES_RST;
  logic [POINT_W-1:0]      lim_pts   = MAX_POINTS_RST;
  logic [GRID_W-1:0]       lim_grid  = MAX_GRID_CELLS_RST;

  // validator copy: parse state
  phase_t                  ph = PH_HEADER;
  logic [7:0]              short_field[4] = '{default: 8'd0};
  int unsigned             short_fill = 0;
  logic [1:0]              ver = 2'd0;
  logic [COUNT_W-1:0]      recs_left = '0;
  logic [FEATURE_W-1:0]    feat_tot = '0;
  logic [POINT_W-1:0]      pts_tot = '0;
  logic [GRID_W-1:0]       cells_tot = '0;
  logic [BYTE_TOTAL_W-1:0] bytes_tot = '0;
  logic [BYTES_LEFT_W-1:0] run_left = '0;
  logic [7:0]              rec_buf[FIXED_BUFFER_BYTES_DEF] = '{default: 8'd0};
  int unsigned             rec_fill = 0;
  bit                      broken = 1'b0;

  function automatic logic [3:0] cell_of(logic [7:0] lo, logic [7:0] hi);
    logic [15:0] raw;
    raw = {hi, lo};
    if (raw == 16'd0 || raw[15]) begin
      return 4'd0;
    end
    if (raw[15:8] > 8'(CELL_MAX)) begin
      return CELL_MAX;
    end
    return raw[11:8];
  endfunction

  function automatic logic [7:0] buf_at(int unsigned i);
    return (i < FIXED_BUFFER_BYTES_DEF) ? rec_buf[i] : 8'd0;
  endfunction

  function automatic bit count_cells();
    int unsigned off;
    int unsigned n;
    logic [3:0]  x0, y0, x1, y1;
    off = (ver == VERSION_2) ? 4 : 3;
    x0 = cell_of(buf_at(off), buf_at(off + 1));
    y0 = cell_of(buf_at(off + 2), buf_at(off + 3));
    x1 = cell_of(buf_at(off + 4), buf_at(off + 5));
    y1 = cell_of(buf_at(off + 6), buf_at(off + 7));
    if (x0 > x1 || y0 > y1) begin
      return 1'b1;
    end
    n = (int'(x1) - int'(x0) + 1) * (int'(y1) - int'(y0) + 1);
    if (longint'(cells_tot) + longint'(n) > longint'(lim_grid)) begin
      return 1'b0;
    end
    cells_tot = cells_tot + GRID_W'(n);
    return 1'b1;
  endfunction

  function automatic logic [BYTES_LEFT_W-1:0] record_head_len(bit poly);
    logic [BYTES_LEFT_W-1:0] len;
    len = poly ? BYTES_LEFT_W'(FIX_LEN_POLYLINE) : BYTES_LEFT_W'(FIX_LEN_POLYGON);
    if (ver == VERSION_2) begin
      len = len + 1'b1;
    end
    return len;
  endfunction

  function automatic void open_run(phase_t nxt, logic [BYTES_LEFT_W-1:0] cnt);
    ph = nxt;
    run_left = cnt;
    rec_fill = 0;
  endfunction

  function automatic bit take_npts(logic [15:0] v, phase_t nxt);
    if (v == 16'd0) begin
      return 1'b0;
    end
    if (longint'(pts_tot) + longint'(v) > longint'(lim_pts)) begin
      return 1'b0;
    end
    pts_tot = pts_tot + POINT_W'(v);
    open_run(nxt, {v, 2'b00});
    return 1'b1;
  endfunction

  function automatic bit take_byte(logic [7:0] b);
    logic [15:0] v;
    bit          poly;
    if (ph == PH_HEADER) begin
      short_field[short_fill & 3] = b;
      short_fill++;
      if (short_fill < 4) begin
        return 1'b1;
      end
      short_fill = 0;
      if (short_field[0] != MAGIC_0 || short_field[1] != MAGIC_1 ||
          short_field[2] != MAGIC_2) begin
        return 1'b0;
      end
      if (short_field[3] != {6'd0, VERSION_1} && short_field[3] != {6'd0, VERSION_2}) begin
        return 1'b0;
      end
      ver = short_field[3][1:0];
      ph = PH_PG_COUNT;
      return 1'b1;
    end
    if (ph == PH_PG_COUNT || ph == PH_PG_NPTS || ph == PH_PL_COUNT || ph == PH_PL_NPTS) begin
      short_field[short_fill & 1] = b;
      short_fill++;
      if (short_fill < 2) begin
        return 1'b1;
      end
      short_fill = 0;
      v = {short_field[1], short_field[0]};
      if (ph == PH_PG_COUNT) begin
        recs_left = v;
        if (longint'(v) > longint'(lim_feat)) begin
          return 1'b0;
        end
        feat_tot = FEATURE_W'(v);
        if (v == 16'd0) begin
          ph = PH_PL_COUNT;
        end else begin
          open_run(PH_PG_FIXED, record_head_len(1'b0));
        end
        return 1'b1;
      end
      if (ph == PH_PL_COUNT) begin
        recs_left = v;
        if (longint'(feat_tot) + longint'(v) > longint'(lim_feat)) begin
          return 1'b0;
        end
        feat_tot = feat_tot + FEATURE_W'(v);
        if (v == 16'd0) begin
          ph = PH_DONE;
        end else begin
          open_run(PH_PL_FIXED, record_head_len(1'b1));
        end
        return 1'b1;
      end
      if (ph == PH_PG_NPTS) begin
        return take_npts(v, PH_PG_PTS);
      end
      return take_npts(v, PH_PL_PTS);
    end
    if (ph != PH_PG_FIXED && ph != PH_PG_PTS && ph != PH_PL_FIXED && ph != PH_PL_PTS) begin
      return 1'b0;
    end
    if (run_left == '0) begin
      return 1'b0;
    end
    if (ph == PH_PG_FIXED) begin
      if (rec_fill >= FIXED_BUFFER_BYTES_DEF) begin
        return 1'b0;
      end
      rec_buf[rec_fill] = b;
      rec_fill++;
    end
    run_left = run_left - 1'b1;
    if (run_left != '0) begin
      return 1'b1;
    end
    if (ph == PH_PG_FIXED) begin
      if (!count_cells()) begin
        return 1'b0;
      end
      ph = PH_PG_NPTS;
    end else if (ph == PH_PL_FIXED) begin
      ph = PH_PL_NPTS;
    end else begin
      poly = (ph == PH_PL_PTS);
      recs_left = recs_left - 1'b1;
      if (recs_left == '0) begin
        if (poly) begin
          ph = PH_DONE;
        end else begin
          ph = PH_PL_COUNT;
        end
      end else if (poly) begin
        open_run(PH_PL_FIXED, record_head_len(1'b1));
      end else begin
        open_run(PH_PG_FIXED, record_head_len(1'b0));
      end
    end
    return 1'b1;
  endfunction

  function automatic result_t judge_item(logic [7:0] b, logic last);
    result_t r;
    if (last) begin
      if (!broken && ph == PH_DONE) begin
        r.status = ST_END_VALID;
      end else begin
        r.status = ST_END_INVALID;
      end
    end else if (broken) begin
      r.status = ST_REJECT;
    end else if (bytes_tot >= lim_bytes) begin
      broken = 1'b1;
      r.status = ST_REJECT;
    end else begin
      bytes_tot = bytes_tot + 1'b1;
      if (take_byte(b)) begin
        r.status = ST_ACCEPT;
      end else begin
        broken = 1'b1;
        r.status = ST_REJECT;
      end
    end
    r.version = ver;
    return r;
  endfunction

  // driver: present queued bytes, hold until taken
  always @(posedge clk) begin : drive_p
    feed_t       f;
    result_t     verdict;
    int unsigned gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict = judge_item(in_tdata, in_tuser);
        verdicts_due.insert(verdicts_due.size(), verdict);
      end
      if (!in_tvalid || in_tready) begin
        if (in_tvalid && !quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 3);
        end
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          f = bytes_to_send.pop_front();
          in_tdata  <= f.data;
          in_tuser  <= f.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest verdict
  always @(posedge clk) begin : watch_p
    result_t     want;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("result %0d arrived with nothing pending: tdata %h",
                     results_seen, out_tdata);
          end
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_tdata[1:0] !== want.status || out_tdata[3:2] !== want.version) begin
            if (mismatches < 10) begin
              $display("result %0d: status exp %0d got %0d, version exp %0d got %0d",
                       results_seen, want.status, out_tdata[1:0], want.version,
                       out_tdata[3:2]);
            end
            mismatches++;
          end
        end
        results_seen++;
      end
      if (!held && results_seen >= 60 && bytes_to_send.size() > 100) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin : watchdog_p
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_item(logic [7:0] b, logic last);
    feed_t f;
    f.data = b;
    f.last = last;
    bytes_to_send.insert(bytes_to_send.size(), f);
  endtask

  task automatic push_end();
    logic [7:0] junk;
    junk = 8'($urandom);
    push_item(junk, 1'b1);
  endtask

  task automatic push_byte(logic [7:0] b);
    if (scatter_ends && $urandom_range(0, 23) == 0) begin
      push_end();
    end
    push_item(b, 1'b0);
  endtask

  task automatic push_u16(logic [15:0] v);
    push_byte(v[7:0]);
    push_byte(v[15:8]);
  endtask

  task automatic push_noise(int n);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom));
    end
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return {1'b1, 15'($urandom)};
      2: return 16'($urandom_range(16'h1000, 16'h7FFF));
      default: return 16'($urandom_range(0, 16'h0FFF));
    endcase
  endfunction

  function automatic int rand_npts();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(7, 12);
    end
    return $urandom_range(1, 6);
  endfunction

  task automatic push_polygon(int npts, bit empty_box, bit plain);
    logic [7:0]  head[13];
    logic [15:0] c[4];
    logic [15:0] t;
    int          len;
    int          off;
    len = 11 + ((ver_sel == VERSION_2) ? 1 : 0);
    off = (ver_sel == VERSION_2) ? 4 : 3;
    for (int i = 0; i < len; i++) begin
      head[i] = plain ? ((i % 2 == 0) ? 8'h00 : 8'hFF) : 8'($urandom);
    end
    for (int k = 0; k < 4; k++) begin
      c[k] = rand_coord();
    end
    if (empty_box) begin
      c[0] = 16'($urandom_range(16'h0800, 16'h0FFF));
      c[2] = 16'($urandom_range(16'h0100, 16'h07FF));
    end else begin
      for (int k = 0; k < 2; k++) begin
        if ($signed(c[k]) > $signed(c[k + 2]) && $urandom_range(0, 7) != 0) begin
          t = c[k];
          c[k] = c[k + 2];
          c[k + 2] = t;
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      head[off + 2 * k]     = c[k][7:0];
      head[off + 2 * k + 1] = c[k][15:8];
    end
    for (int i = 0; i < len; i++) begin
      push_byte(head[i]);
    end
    push_u16(16'(npts));
    for (int i = 0; i < 4 * npts; i++) begin
      push_byte(plain ? ((i % 2 == 0) ? 8'h00 : 8'hFF) : 8'($urandom));
    end
  endtask

  task automatic push_polyline(int npts, bit with_points);
    int len;
    len = 12 + ((ver_sel == VERSION_2) ? 1 : 0);
    push_noise(len);
    push_u16(16'(npts));
    if (with_points) begin
      push_noise(4 * npts);
    end
  endtask

  task automatic settle();
    while (bytes_to_send.size() != 0 || in_tvalid || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MAX_BLOCK_BYTES: lim_bytes = val[BYTE_TOTAL_W-1:0];
      CFG_MAX_FEATURES:    lim_feat  = val[FEATURE_W-1:0];
      CFG_MAX_POINTS:      lim_pts   = val[POINT_W-1:0];
      default:             lim_grid  = val[GRID_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // end modes: 0 byte after completion, 1 zero point count, 2 point limit,
  // 3 byte limit, 4 feature limit
  initial begin : stimulus_p
    int n_pg;
    int n_pl;
    int mode;
    int pts_sum;
    int npl[$];
    ver_sel = 2'($urandom_range(1, 2));
    mode = $urandom_range(0, 4);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_end();
    push_byte(MAGIC_0);
    push_byte(MAGIC_1);
    push_byte(MAGIC_2);
    push_byte({6'd0, ver_sel});
    push_end();
    n_pg = $urandom_range(6, 10);
    push_u16(16'(n_pg));
    settle();

    // empty bbox must pass even with no cells left
    write_limit(CFG_MAX_GRID_CELLS, '0);
    write_limit(CFG_MAX_FEATURES, '0);
    write_limit(CFG_MAX_BLOCK_BYTES, 24'hFFFFFF);
    write_limit(CFG_MAX_POINTS, 24'h0FFFFF);
    push_polygon(1, 1'b1, 1'b1);
    settle();

    write_limit(CFG_MAX_GRID_CELLS, 24'h0FFFFF);
    write_limit(CFG_MAX_FEATURES, 24'd131070);
    scatter_ends = 1'b1;
    for (int i = 0; i < n_pg - 1; i++) begin
      push_polygon(rand_npts(), $urandom_range(0, 5) == 0, 1'b0);
    end
    settle();

    n_pl = $urandom_range(3, 7);
    npl.insert(npl.size(), 256 + $urandom_range(0, 3));
    for (int i = 1; i < n_pl; i++) begin
      npl.insert(npl.size(), rand_npts());
    end
    if (mode == 1) begin
      npl[n_pl - 1] = 0;
    end
    pts_sum = 0;
    foreach (npl[i]) begin
      pts_sum += npl[i];
    end
    // tight limits: exact fit, or one short to force the chosen failure
    write_limit(CFG_MAX_FEATURES, CFG_DATA_W'(int'(feat_tot) + n_pl - ((mode == 4) ? 1 : 0)));
    write_limit(CFG_MAX_POINTS, CFG_DATA_W'(int'(pts_tot) + pts_sum - ((mode == 2) ? 1 : 0)));
    push_u16(16'(n_pl));
    for (int i = 0; i < n_pl; i++) begin
      push_polyline(npl[i], i != n_pl - 1 || mode == 0 || mode == 3);
    end
    settle();

    if (mode == 3) begin
      write_limit(CFG_MAX_BLOCK_BYTES, ($urandom_range(0, 1) == 0) ? '0 : bytes_tot);
    end
    quiet = 1'b1;
    push_end();
    push_noise(60);
    push_end();
    settle();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/bmbv_pkg.sv
rtl/core/bmbv_core.sv
rtl/core/binary_map_block_validator.sv
tb/tb_top.sv
